// ===== rtl/core/phd_pkg.sv =====
// Packet header deframer package: shared constants, result kinds, phase type
// and the result record passed between the parser and the output register.
// No dependencies.
package phd_pkg;

    localparam int BYTE_W       = 8;
    localparam int HEADER_BYTES = 7;
    localparam int CNT_W        = 3;
    localparam logic [CNT_W-1:0] STORE_DEPTH = CNT_W'(HEADER_BYTES - 1);
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'hFF;
    localparam int TDATA_W      = 64;
    localparam int TUSER_W      = 2;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic {
        PHASE_HEADER  = 1'b0,
        PHASE_PAYLOAD = 1'b1
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  src_node;
        logic [7:0]  dst_node;
        logic [7:0]  packet_id;
        logic [3:0]  ttl;
        logic [3:0]  packet_type;
        logic [7:0]  body_len;
        logic [15:0] crc;
        logic [7:0]  data;
        logic        last;
    } phd_result_t;

endpackage

// ===== rtl/core/packet_header_deframer.sv =====
// Packet header deframer top level: config register, parser and output register.
// Depends on phd_pkg, phd_parser and phd_out_reg.
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    rx_byte
//  m_        out        m_tvalid / m_tready    kind, header fields, data, last
//  cfg_      in         cfg_valid / cfg_ready  max_payload
//
// One byte is accepted per cycle while s_tready is high; a result appears on
// m_ in the cycle after the byte that causes it. Throughput is set by the single
// output register, which loads in the same cycle its previous result is taken.
// s_tready falls only while a result waits and m_tready is low.
// aresetn (synchronous) returns to header collection and sets max_payload to 255.
module packet_header_deframer import phd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] src_node, [15:8] dst_node, [23:16] packet_id, [27:24] ttl,
    // [31:28] packet_type, [39:32] body_len, [55:40] crc, [63:56] data
    output logic [TDATA_W-1:0] m_tdata,
    output logic [TUSER_W-1:0] m_tuser,   // [1:0] kind
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BYTE_W-1:0]  cfg_data   // [7:0] max_payload
);

    logic [BYTE_W-1:0] max_payload_reg;
    logic              in_accept;
    logic              res_valid;
    logic              free;
    phd_result_t       res;
    phd_result_t       out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_valid) begin
            max_payload_reg <= cfg_data;
        end
    end

    assign s_tready  = free;
    assign in_accept = s_tvalid && free;

    phd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .max_payload (max_payload_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    phd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_accept && res_valid),
        .load_res  (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .free      (free),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.data, out_res.crc, out_res.body_len,
                      out_res.packet_type, out_res.ttl, out_res.packet_id,
                      out_res.dst_node, out_res.src_node};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast)
        else $error("error result without last");

    a_payload_no_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[55:0] == '0)
        else $error("payload result carries header fields");

    a_header_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[63:56] == '0)
        else $error("non-payload result carries data");

    a_empty_header_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_HEADER && m_tlast |-> m_tdata[39:32] == '0)
        else $error("header closed a packet that has payload");

endmodule

// ===== rtl/core/phd_parser.sv =====
// Header/payload parser: phase register, header byte capture, payload countdown.
// Builds one result record per qualifying byte. Depends on phd_pkg.
module phd_parser import phd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [BYTE_W-1:0] max_payload,
    output logic              res_valid,
    output phd_result_t       res
);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]  left_reg, left_next;
    logic [BYTE_W-1:0]  store_reg [HEADER_BYTES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_HEADER;
            count_reg <= '0;
            left_reg  <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

    // header bytes 0..5; the crc low byte is used straight from the input
    always_ff @(posedge aclk) begin
        if (in_accept && phase_reg == PHASE_HEADER && count_reg < STORE_DEPTH) begin
            store_reg[count_reg] <= in_byte;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind   = KIND_HEADER;
        case (phase_reg)
            PHASE_PAYLOAD: begin
                res_valid = 1'b1;
                res.kind  = KIND_PAYLOAD;
                res.data  = in_byte;
                if (left_reg <= 8'd1) begin
                    res.last   = 1'b1;
                    left_next  = '0;
                    phase_next = PHASE_HEADER;
                end else begin
                    left_next = left_reg - 8'd1;
                end
            end
            PHASE_HEADER: begin
                if (count_reg < STORE_DEPTH) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    res_valid       = 1'b1;
                    count_next      = '0;
                    res.src_node    = store_reg[0];
                    res.dst_node    = store_reg[1];
                    res.packet_id   = store_reg[2];
                    res.ttl         = store_reg[3][7:4];
                    res.packet_type = store_reg[3][3:0];
                    res.body_len    = store_reg[4];
                    res.crc         = {store_reg[5], in_byte};
                    left_next       = '0;
                    if (store_reg[4] > max_payload) begin
                        res.kind = KIND_ERROR;
                        res.last = 1'b1;
                    end else if (store_reg[4] == '0) begin
                        res.last = 1'b1;
                    end else begin
                        left_next  = store_reg[4];
                        phase_next = PHASE_PAYLOAD;
                    end
                end
            end
            default: begin
                phase_next = PHASE_HEADER;
            end
        endcase
    end

endmodule

// ===== rtl/core/phd_out_reg.sv =====
// Output register for result records: holds one result until the sink takes it.
// Loads in the same cycle the previous one leaves. Depends on phd_pkg.
module phd_out_reg import phd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  phd_result_t load_res,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        free,
    output phd_result_t out_res
);

    logic        valid_reg;
    phd_result_t res_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

endmodule
